### design/scfla_pkg.sv
`default_nettype none
package scfla_pkg;

   localparam int NODE_COUNT   = 256;
   localparam int CLASS_COUNT  = 80;
   localparam int BLOCK_SHIFT  = 7;
   localparam int MIN_BYTES    = 256;
   localparam int HEADER_BYTES = 32;

   localparam int NODE_W  = 8;
   localparam int CLASS_W = 26;
   localparam int BKT_W   = 7;
   localparam int STEP_W  = 9;
   localparam int BYTES_W = 32;

   localparam int BLOCK_MASK = (1 << BLOCK_SHIFT) - 1;
   localparam int MIN_BLOCKS = MIN_BYTES >> BLOCK_SHIFT;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [2:0] ST_GRANT_BUCKET = 3'd0;
   localparam logic [2:0] ST_GRANT_OVER   = 3'd1;
   localparam logic [2:0] ST_MISS         = 3'd2;
   localparam logic [2:0] ST_STORED       = 3'd3;
   localparam logic [2:0] ST_RELEASED     = 3'd4;

   typedef struct packed {
      logic               func;
      logic [BYTES_W-1:0] req_bytes;
      logic [NODE_W-1:0]  node_handle;
      logic [CLASS_W-1:0] node_class;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [NODE_W-1:0]  out_handle;
      logic [CLASS_W-1:0] out_class;
   } rsp_type;

   typedef struct packed {
      logic               func;
      logic [NODE_W-1:0]  handle;
      logic [CLASS_W-1:0] cls;
   } job_type;

   typedef struct packed {
      logic valid;
      logic [NODE_W-1:0] next;
   } link_type;

endpackage
`default_nettype wire

### design/scfla_front.sv
`default_nettype none
module scfla_front (
   input  wire scfla_pkg::req_type req_item,
   output scfla_pkg::job_type      job
);
   logic [scfla_pkg::BYTES_W:0]    sum;
   logic [scfla_pkg::CLASS_W-1:0] blocks;
   logic [scfla_pkg::CLASS_W-1:0] blocks_min;

   always_comb begin
      sum = {1'b0, req_item.req_bytes}
          + (scfla_pkg::BYTES_W+1)'(scfla_pkg::HEADER_BYTES + scfla_pkg::BLOCK_MASK);
      blocks = sum[scfla_pkg::BYTES_W:scfla_pkg::BLOCK_SHIFT];
      blocks_min = (blocks < scfla_pkg::CLASS_W'(scfla_pkg::MIN_BLOCKS))
                 ? scfla_pkg::CLASS_W'(scfla_pkg::MIN_BLOCKS) : blocks;
      job.func   = req_item.func;
      job.handle = req_item.node_handle;
      job.cls    = (req_item.func == scfla_pkg::FUNC_FREE) ? req_item.node_class
                 : blocks_min - scfla_pkg::CLASS_W'(1);
   end
endmodule
`default_nettype wire

### design/scfla_queue.sv
`default_nettype none
module scfla_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire scfla_pkg::job_type push_job,
   input  wire                     pop,
   output scfla_pkg::job_type      pop_job,
   output logic                    empty,
   output logic                    full
);
   scfla_pkg::job_type slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      empty  = (cnt_ff == 2'd0);
      full   = (cnt_ff == 2'd2);
      pop_job = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

### design/scfla_back.sv
`default_nettype none
module scfla_back (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire [scfla_pkg::CLASS_W-1:0]       csr_wr_data,
   input  wire                                q_empty,
   input  wire scfla_pkg::job_type            q_job,
   output logic                               q_pop,
   output logic                               rsp_valid,
   output scfla_pkg::rsp_type                 rsp_item
);
   localparam int CW = scfla_pkg::CLASS_W;
   localparam int NW = scfla_pkg::NODE_W;
   localparam int BW = scfla_pkg::BKT_W;
   localparam int SW = scfla_pkg::STEP_W;
   localparam int CC = scfla_pkg::CLASS_COUNT;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_ALLOC = 11'b00000000010,
      S_SCAN  = 11'b00000000100,
      S_HRD   = 11'b00000001000,
      S_LRD   = 11'b00000010000,
      S_LOWER = 11'b00000100000,
      S_WHEAD = 11'b00001000000,
      S_WCHK  = 11'b00010000000,
      S_WFIX  = 11'b00100000000,
      S_FREE0 = 11'b01000000000,
      S_FREE1 = 11'b10000000000
   } state_type;

   state_type          state_ff, state_in;
   scfla_pkg::job_type job_ff, job_in;
   logic [BW-1:0]      idx_ff, idx_in;
   logic [NW-1:0]      cur_ff, cur_in;
   logic [NW-1:0]      prev_ff, prev_in;
   logic [SW-1:0]      steps_ff, steps_in;
   logic [BW-1:0]      hi_ff, hi_in;
   logic [CC-1:0]      bv_ff, bv_in;
   logic [CW-1:0]      credit_ff, credit_in;
   logic [CW-1:0]      max_ff, max_in;
   logic               rsp_valid_ff, rsp_valid_in;
   scfla_pkg::rsp_type rsp_ff, rsp_in;

   logic [NW-1:0]       head_mem [CC];
   scfla_pkg::link_type link_mem [scfla_pkg::NODE_COUNT];
   logic [CW-1:0]       cls_mem  [scfla_pkg::NODE_COUNT];

   logic [BW-1:0]       head_raddr, head_waddr;
   logic                head_we;
   logic [NW-1:0]       head_wdata, head_rd_ff;
   logic [NW-1:0]       node_raddr, link_waddr, cls_waddr;
   logic                link_we, cls_we;
   scfla_pkg::link_type link_wdata, link_rd_ff;
   logic [CW-1:0]       cls_wdata, cls_rd_ff;

   logic [CW:0]   add_sum, cfg_sum;
   logic [CW-1:0] add_clamp, cfg_val;
   logic [BW-1:0] bkt, mdec;
   logic          cls_le_hi;

   always_comb begin
      add_sum   = {1'b0, credit_ff} + {1'b0, cls_rd_ff};
      add_clamp = (add_sum > {1'b0, max_ff}) ? max_ff : add_sum[CW-1:0];
      cfg_sum   = {1'b0, credit_ff} + {1'b0, csr_wr_data};
      if (cfg_sum < {1'b0, max_ff}) begin
         cfg_val = csr_wr_data;
      end else if ((cfg_sum - {1'b0, max_ff}) > {1'b0, csr_wr_data}) begin
         cfg_val = csr_wr_data;
      end else begin
         cfg_val = CW'(cfg_sum - {1'b0, max_ff});
      end
      bkt       = (job_ff.cls < CW'(CC)) ? job_ff.cls[BW-1:0] : '0;
      cls_le_hi = (job_ff.cls <= CW'(hi_ff));
      mdec      = idx_ff - BW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      hi_in        = hi_ff;
      bv_in        = bv_ff;
      credit_in    = credit_ff;
      max_in       = max_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      head_raddr   = idx_ff;
      head_we      = 1'b0;
      head_waddr   = idx_ff;
      head_wdata   = cur_ff;
      node_raddr   = cur_ff;
      link_we      = 1'b0;
      link_waddr   = cur_ff;
      link_wdata   = link_rd_ff;
      cls_we       = 1'b0;
      cls_waddr    = job_ff.handle;
      cls_wdata    = job_ff.cls;

      if (csr_wr_en) begin
         max_in    = csr_wr_data;
         credit_in = cfg_val;
      end

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               job_in = q_job;
               state_in = (q_job.func == scfla_pkg::FUNC_FREE) ? S_FREE0 : S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (cls_le_hi) begin
               idx_in   = job_ff.cls[BW-1:0];
               state_in = S_SCAN;
            end else if (bv_ff[0]) begin
               head_raddr = '0;
               state_in   = S_WHEAD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{scfla_pkg::ST_MISS, '0, job_ff.cls};
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (!bv_ff[idx_ff] && idx_ff < hi_ff) begin
               idx_in = idx_ff + BW'(1);
            end else if (bv_ff[idx_ff]) begin
               head_raddr = idx_ff;
               state_in   = S_HRD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{scfla_pkg::ST_MISS, '0, job_ff.cls};
               state_in = S_IDLE;
            end
         end
         S_HRD: begin
            cur_in     = head_rd_ff;
            node_raddr = head_rd_ff;
            state_in   = S_LRD;
         end
         S_LRD: begin
            head_we    = 1'b1;
            head_waddr = idx_ff;
            head_wdata = link_rd_ff.next;
            bv_in[idx_ff] = link_rd_ff.valid;
            link_we    = 1'b1;
            link_waddr = cur_ff;
            link_wdata = '{1'b0, link_rd_ff.next};
            if (!csr_wr_en) begin
               credit_in = add_clamp;
            end
            rsp_valid_in = 1'b1;
            rsp_in = '{scfla_pkg::ST_GRANT_BUCKET, cur_ff, cls_rd_ff};
            if (!link_rd_ff.valid && idx_ff >= hi_ff && hi_ff != '0) begin
               idx_in   = hi_ff;
               state_in = S_LOWER;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_LOWER: begin
            if (bv_ff[mdec] || mdec == '0) begin
               hi_in    = mdec;
               state_in = S_IDLE;
            end else begin
               idx_in = mdec;
            end
         end
         S_WHEAD: begin
            cur_in     = head_rd_ff;
            node_raddr = head_rd_ff;
            steps_in   = '0;
            state_in   = S_WCHK;
         end
         S_WCHK: begin
            if (job_ff.cls <= cls_rd_ff) begin
               if (steps_ff == '0) begin
                  head_we    = 1'b1;
                  head_waddr = '0;
                  head_wdata = link_rd_ff.next;
                  bv_in[0]   = link_rd_ff.valid;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff;
                  link_wdata = link_rd_ff;
               end
               if (!csr_wr_en) begin
                  credit_in = add_clamp;
               end
               rsp_valid_in = 1'b1;
               rsp_in = '{scfla_pkg::ST_GRANT_OVER, cur_ff, cls_rd_ff};
               state_in = S_WFIX;
            end else if (!link_rd_ff.valid || steps_ff[SW-1]) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{scfla_pkg::ST_MISS, '0, job_ff.cls};
               state_in = S_IDLE;
            end else begin
               prev_in    = cur_ff;
               cur_in     = link_rd_ff.next;
               node_raddr = link_rd_ff.next;
               steps_in   = steps_ff + SW'(1);
            end
         end
         S_WFIX: begin
            link_we    = 1'b1;
            link_waddr = cur_ff;
            link_wdata = '{1'b0, cur_ff};
            state_in   = S_IDLE;
         end
         S_FREE0: begin
            cls_we = 1'b1;
            if (max_ff != '0 && job_ff.cls > credit_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{scfla_pkg::ST_RELEASED, job_ff.handle, job_ff.cls};
               state_in = S_IDLE;
            end else begin
               head_raddr = bkt;
               state_in   = S_FREE1;
            end
         end
         S_FREE1: begin
            link_we    = 1'b1;
            link_waddr = job_ff.handle;
            link_wdata = '{bv_ff[bkt], head_rd_ff};
            if (job_ff.cls < CW'(CC) && !bv_ff[bkt] && job_ff.cls > CW'(hi_ff)) begin
               hi_in = job_ff.cls[BW-1:0];
            end
            head_we    = 1'b1;
            head_waddr = bkt;
            head_wdata = job_ff.handle;
            bv_in[bkt] = 1'b1;
            if (!csr_wr_en) begin
               credit_in = (credit_ff >= job_ff.cls) ? credit_ff - job_ff.cls : '0;
            end
            rsp_valid_in = 1'b1;
            rsp_in = '{scfla_pkg::ST_STORED, job_ff.handle, job_ff.cls};
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= head_mem[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (cls_we) begin
         cls_mem[cls_waddr] <= cls_wdata;
      end
      cls_rd_ff <= cls_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      idx_ff   <= idx_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      steps_ff <= steps_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         hi_ff        <= '0;
         bv_ff        <= '0;
         credit_ff    <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hi_ff        <= hi_in;
         bv_ff        <= bv_in;
         credit_ff    <= credit_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule
`default_nettype wire

### design/size_class_free_list_allocator.sv
// channel | ports                          | transfer
// input   | start, busy, req_item          | start && !busy
// result  | rsp_valid, rsp_item            | rsp_valid, one cycle, no stall
// config  | csr_wr_en, csr_wr_data         | csr_wr_en
// A free leaves the queue into S_FREE0, which answers a release itself or goes on to S_FREE1.
// An allocate passes S_ALLOC, S_SCAN per bucket scanned, S_HRD, S_LRD and S_LOWER per step
// lowering the highest mark; an oversize one S_WHEAD, S_WCHK per node walked and S_WFIX.
// A two-entry queue sits between classification and the sequencer; busy means it is full.
// Reset empties every bucket and clears highest mark, credit and limit; no clearing pass.
`default_nettype none
module size_class_free_list_allocator (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire scfla_pkg::req_type      req_item,
   output logic                         rsp_valid,
   output scfla_pkg::rsp_type           rsp_item,
   input  wire                          csr_wr_en,
   input  wire [scfla_pkg::CLASS_W-1:0] csr_wr_data
);
   scfla_pkg::job_type front_job, q_job;
   logic q_empty, q_full, q_pop;

   scfla_front u_front (
      .req_item (req_item),
      .job      (front_job)
   );

   scfla_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (start && !q_full),
      .push_job (front_job),
      .pop      (q_pop),
      .pop_job  (q_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   scfla_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_empty     (q_empty),
      .q_job       (q_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

   assign busy = q_full;
endmodule
`default_nettype wire

### tb/size_class_free_list_allocator_tb.sv
`timescale 1ns / 1ps
module size_class_free_list_allocator_tb;
   import scfla_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_valid;
   rsp_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [CLASS_W-1:0] csr_wr_data = '0;

   size_class_free_list_allocator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // allocator shadow state
   logic [NODE_W-1:0]  head_of[CLASS_COUNT];
   logic               head_vld[CLASS_COUNT];
   logic [NODE_W-1:0]  link_of[NODE_COUNT];
   logic               link_vld[NODE_COUNT];
   logic [CLASS_W-1:0] class_of[NODE_COUNT];
   int unsigned        highest_mark;
   longint unsigned    credit;
   longint unsigned    block_limit;

   rsp_type     pending_rsp[$];
   logic [7:0]  held_handles[$];
   int          fail_count = 0;
   bit          idle_on = 1'b1;

   initial forever #10 clock = ~clock;

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic rsp_type push_result(logic [2:0] st, logic [7:0] h,
                                           longint unsigned c);
      rsp_type r;
      r.status = st;
      r.out_handle = h;
      r.out_class = c[CLASS_W-1:0];
      return r;
   endfunction

   function automatic void add_credit(longint unsigned c);
      credit = credit + c;
      if (credit > block_limit) credit = block_limit;
   endfunction

   function automatic rsp_type allocator_predict(req_type it);
      longint unsigned sz, cls, fc;
      int unsigned i, m, steps;
      logic [7:0] h, cur, prv;
      bit ok;
      if (it.func == FUNC_FREE) begin
         h = it.node_handle;
         fc = it.node_class;
         class_of[h] = it.node_class;
         if (block_limit != 0 && fc > credit) return push_result(ST_RELEASED, h, fc);
         i = (fc < CLASS_COUNT) ? 32'(fc) : 0;
         link_of[h] = head_of[i];
         link_vld[h] = head_vld[i];
         if (fc < CLASS_COUNT && !head_vld[i] && fc > highest_mark) highest_mark = 32'(fc);
         head_of[i] = h;
         head_vld[i] = 1'b1;
         credit = (credit >= fc) ? credit - fc : 0;
         return push_result(ST_STORED, h, fc);
      end
      sz = (longint'(it.req_bytes) + HEADER_BYTES + BLOCK_MASK) & ~64'(BLOCK_MASK);
      if (sz < MIN_BYTES) sz = MIN_BYTES;
      cls = (sz >> BLOCK_SHIFT);
      cls = (cls != 0) ? cls - 1 : 0;
      if (cls <= highest_mark) begin
         i = 32'(cls);
         while (!head_vld[i] && i < highest_mark) i++;
         if (head_vld[i]) begin
            h = head_of[i];
            head_of[i] = link_of[h];
            head_vld[i] = link_vld[h];
            if (!head_vld[i] && i >= highest_mark) begin
               m = highest_mark;
               if (m > 0) begin
                  do m--; while (!head_vld[m] && m > 0);
               end
               highest_mark = m;
            end
            link_vld[h] = 1'b0;
            add_credit(class_of[h]);
            return push_result(ST_GRANT_BUCKET, h, class_of[h]);
         end
      end else if (head_vld[0]) begin
         cur = head_of[0];
         prv = 0;
         steps = 0;
         ok = 1'b1;
         while (ok && steps < NODE_COUNT && cls > class_of[cur]) begin
            prv = cur;
            ok = link_vld[cur];
            cur = link_of[cur];
            steps++;
         end
         if (ok && cls <= class_of[cur]) begin
            if (steps == 0) begin
               head_of[0] = link_of[cur];
               head_vld[0] = link_vld[cur];
            end else begin
               link_of[prv] = link_of[cur];
               link_vld[prv] = link_vld[cur];
            end
            link_vld[cur] = 1'b0;
            add_credit(class_of[cur]);
            return push_result(ST_GRANT_OVER, cur, class_of[cur]);
         end
      end
      return push_result(ST_MISS, 8'd0, cls);
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected transfer: status %0d handle %0d class %0d",
                   rsp_item.status, rsp_item.out_handle, rsp_item.out_class);
            fail_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_item.status !== exp_rsp.status) begin
               $error("status: expected %0d actual %0d", exp_rsp.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.out_handle !== exp_rsp.out_handle) begin
               $error("out_handle: expected %0d actual %0d",
                      exp_rsp.out_handle, rsp_item.out_handle);
               fail_count++;
            end
            if (rsp_item.out_class !== exp_rsp.out_class) begin
               $error("out_class: expected %0d actual %0d",
                      exp_rsp.out_class, rsp_item.out_class);
               fail_count++;
            end
         end
      end
   end

   task automatic send_item(req_type it);
      int gap;
      rsp_type r;
      gap = idle_on ? $urandom_range(0, 13) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item = it;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = allocator_predict(it);
      pending_rsp.push_back(r);
      if (r.status == ST_GRANT_BUCKET || r.status == ST_GRANT_OVER ||
          r.status == ST_RELEASED)
         held_handles.push_back(r.out_handle);
   endtask

   task automatic send_alloc(logic [31:0] bytes);
      req_type it;
      it = '0;
      it.func = FUNC_ALLOC;
      it.req_bytes = bytes;
      it.node_handle = NODE_W'($urandom);
      it.node_class = CLASS_W'($urandom);
      send_item(it);
   endtask

   task automatic send_free(logic [7:0] h, logic [CLASS_W-1:0] c);
      req_type it;
      int idx;
      it.func = FUNC_FREE;
      it.req_bytes = $urandom;
      it.node_handle = h;
      it.node_class = c;
      for (idx = 0; idx < held_handles.size(); idx++)
         if (held_handles[idx] == h) begin
            held_handles.delete(idx);
            break;
         end
      send_item(it);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_limit(logic [CLASS_W-1:0] v);
      longint unsigned nv, c;
      wait_idle();
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      @(posedge clock);
      nv = v;
      c = credit + nv;
      if (c < block_limit) c = nv;
      else c = c - block_limit;
      if (c > nv) c = nv;
      block_limit = nv;
      credit = c;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic test_buckets_and_sink();
      send_free(8'd1, 26'd1);
      send_free(8'd2, 26'd5);
      send_free(8'd3, 26'd79);
      send_free(8'd4, 26'd100);
      send_free(8'd5, 26'h3ffffff);
      send_free(8'd255, 26'd0);
      send_alloc(32'd0);
      send_alloc(32'hffffffff);
      send_alloc(32'd12800);
      send_alloc(32'd200);
      send_alloc(32'd6000);
      send_alloc(32'd0);
      send_alloc(32'd20000);
      send_alloc(32'd0);
   endtask

   task automatic test_double_free();
      send_free(8'd7, 26'd3);
      send_free(8'd7, 26'd3);
      send_free(8'd8, 26'd200);
      send_free(8'd8, 26'd200);
      send_alloc(32'd300);
      send_alloc(32'd300);
      send_alloc(32'd30000);
      send_alloc(32'd30000);
   endtask

   task automatic test_credit_limit();
      write_limit(26'd10);
      send_free(8'd9, 26'd20);
      send_free(8'd10, 26'd3);
      send_free(8'd11, 26'd7);
      send_free(8'd12, 26'd1);
      send_alloc(32'd400);
      write_limit(26'h3ffffff);
      send_free(8'd13, 26'd40);
      write_limit(26'd0);
   endtask

   task automatic random_phase(int count);
      int k, pick;
      logic [7:0] h;
      logic [CLASS_W-1:0] c;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 49) == 0) idle_on = ~idle_on;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 9) == 0) send_alloc($urandom);
            else send_alloc($urandom_range(0, 320 * 128));
         end else if (pick < 92 && held_handles.size() != 0) begin
            h = held_handles[$urandom_range(0, held_handles.size() - 1)];
            if ($urandom_range(0, 4) == 0) c = CLASS_W'($urandom_range(80, 320));
            else c = CLASS_W'($urandom_range(0, 79));
            send_free(h, c);
         end else begin
            h = NODE_W'($urandom);
            c = ($urandom_range(0, 1) != 0) ? CLASS_W'($urandom)
                                            : CLASS_W'($urandom_range(0, 400));
            send_free(h, c);
         end
      end
   endtask

   task automatic test_random();
      random_phase(450);
      write_limit(26'd2000);
      random_phase(450);
      write_limit(26'd1);
      random_phase(300);
      write_limit(CLASS_W'($urandom));
      random_phase(300);
      write_limit(26'd0);
      random_phase(300);
   endtask

   initial begin
      int n;
      foreach (head_vld[j]) head_vld[j] = 1'b0;
      foreach (head_of[j]) head_of[j] = '0;
      foreach (link_vld[j]) link_vld[j] = 1'b0;
      foreach (link_of[j]) link_of[j] = '0;
      foreach (class_of[j]) class_of[j] = '0;
      highest_mark = 0;
      credit = 0;
      block_limit = 0;
      for (n = 0; n < NODE_COUNT; n++) held_handles.push_back(n[7:0]);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_buckets_and_sink();
      test_double_free();
      test_credit_limit();
      test_random();
      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
